// ----- hw/rtl/rcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types, wiring tables and letter arithmetic for the rotor cipher
// letter unit.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int ALPHA    = 26;
  localparam int LETTER_W = 5;
  localparam int STAGES   = 7;
  localparam int WIRE_W   = 8 * ALPHA;

  localparam logic [WIRE_W-1:0] WIRE_FAST = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
  localparam logic [WIRE_W-1:0] WIRE_MED  = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
  localparam logic [WIRE_W-1:0] WIRE_SLOW = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
  localparam logic [WIRE_W-1:0] WIRE_REFL = "IXUHFEZDAOMTKQJWNSRLCYPBVG";

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t slow;
    letter_t med;
    letter_t fast;
  } pos_t;

  typedef struct packed {
    letter_t letter;
    pos_t    pos;
  } token_t;

  typedef enum logic [2:0] {
    STG_FAST,
    STG_MED,
    STG_SLOW,
    STG_REFL,
    STG_SLOW_INV,
    STG_MED_INV,
    STG_FAST_INV
  } stage_t;

  function automatic stage_t stage_of(input int idx);
    stage_t st;
    case (idx)
      0:       st = STG_FAST;
      1:       st = STG_MED;
      2:       st = STG_SLOW;
      3:       st = STG_REFL;
      4:       st = STG_SLOW_INV;
      5:       st = STG_MED_INV;
      default: st = STG_FAST_INV;
    endcase
    return st;
  endfunction

  function automatic letter_t add_mod(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(ALPHA)) begin
      s = s - (LETTER_W+1)'(ALPHA);
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t sub_mod(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (LETTER_W+1)'(ALPHA) - {1'b0, b};
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t wire_char(input logic [WIRE_W-1:0] w, input letter_t i);
    logic [7:0] c;
    c = w[(ALPHA - 1 - int'(i)) * 8 +: 8];
    return LETTER_W'(c - 8'h41);
  endfunction

  function automatic letter_t wire_inv(input logic [WIRE_W-1:0] w, input letter_t x);
    letter_t r;
    r = '0;
    for (int j = 0; j < ALPHA; j++) begin
      if (wire_char(w, LETTER_W'(j)) == x) begin
        r = LETTER_W'(j);
      end
    end
    return r;
  endfunction

  function automatic letter_t stage_map(input stage_t st, input letter_t y);
    letter_t r;
    case (st)
      STG_FAST:     r = wire_char(WIRE_FAST, y);
      STG_MED:      r = wire_char(WIRE_MED, y);
      STG_SLOW:     r = wire_char(WIRE_SLOW, y);
      STG_REFL:     r = wire_char(WIRE_REFL, y);
      STG_SLOW_INV: r = wire_inv(WIRE_SLOW, y);
      STG_MED_INV:  r = wire_inv(WIRE_MED, y);
      STG_FAST_INV: r = wire_inv(WIRE_FAST, y);
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/rcl_cell.sv -----
// ----------------------------------------------------------------------------
// rcl_cell
// One wiring stage: offset the letter by its rotor digit, pass it through
// the fixed wiring and remove the offset; registered with its own handshake.
// ----------------------------------------------------------------------------
module rcl_cell (
  input  logic            clk,
  input  logic            rst,
  input  rcl_pkg::stage_t stage_sel,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcl_pkg::token_t in_tok,
  output logic            out_valid,
  input  logic            out_ready,
  output rcl_pkg::token_t out_tok
);

  logic             valid;
  rcl_pkg::token_t  tok;
  rcl_pkg::letter_t digit;
  rcl_pkg::letter_t shifted;
  rcl_pkg::letter_t mapped;
  rcl_pkg::token_t  tok_next;

  always_comb begin
    case (stage_sel)
      rcl_pkg::STG_FAST, rcl_pkg::STG_FAST_INV: digit = in_tok.pos.fast;
      rcl_pkg::STG_MED,  rcl_pkg::STG_MED_INV:  digit = in_tok.pos.med;
      rcl_pkg::STG_SLOW, rcl_pkg::STG_SLOW_INV: digit = in_tok.pos.slow;
      default:                                  digit = '0;
    endcase
    shifted         = rcl_pkg::add_mod(in_tok.letter, digit);
    mapped          = rcl_pkg::stage_map(stage_sel, shifted);
    tok_next.pos    = in_tok.pos;
    tok_next.letter = rcl_pkg::sub_mod(mapped, digit);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_tok   = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok <= tok_next;
    end
  end

endmodule

// ----- hw/rtl/rotor_cipher_letter_unit.sv -----
// ----------------------------------------------------------------------------
// rotor_cipher_letter_unit
// Three-rotor reflecting letter cipher built as a chain of seven wiring cells.
// ----------------------------------------------------------------------------
// One letter is accepted per cycle while in_ready is high; it is registered once
// in each wiring cell (fast, medium, slow, reflector, then the inverse slow,
// medium and fast rotors). Each letter carries its own rotor position down the
// chain, so the odometer steps at the input transfer and restart simply reloads
// it before that letter. Each cell stalls only when it is full and the next
// cell cannot take its letter, so bubbles close up while the output waits.
// Letters 26..31 are taken as 0..5. Encryption and decryption use the same path.
module rotor_cipher_letter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] letter_in,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] letter_out
);

  localparam int N = rcl_pkg::STAGES;

  rcl_pkg::pos_t    position;
  rcl_pkg::pos_t    position_next;
  rcl_pkg::pos_t    cur_pos;
  rcl_pkg::letter_t letter_in_red;

  logic            valid_c [N+1];
  logic            ready_c [N+1];
  rcl_pkg::token_t tok_c   [N+1];

  always_comb begin
    if (letter_in >= rcl_pkg::LETTER_W'(rcl_pkg::ALPHA)) begin
      letter_in_red = letter_in - rcl_pkg::LETTER_W'(rcl_pkg::ALPHA);
    end else begin
      letter_in_red = letter_in;
    end

    if (restart) begin
      cur_pos      = '0;
      cur_pos.fast = rcl_pkg::LETTER_W'(1);
    end else begin
      cur_pos = position;
    end

    position_next = cur_pos;
    if (cur_pos.fast == rcl_pkg::LETTER_W'(rcl_pkg::ALPHA - 1)) begin
      position_next.fast = '0;
      if (cur_pos.med == rcl_pkg::LETTER_W'(rcl_pkg::ALPHA - 1)) begin
        position_next.med = '0;
        if (cur_pos.slow == rcl_pkg::LETTER_W'(rcl_pkg::ALPHA - 1)) begin
          position_next.slow = '0;
        end else begin
          position_next.slow = cur_pos.slow + 1'b1;
        end
      end else begin
        position_next.med = cur_pos.med + 1'b1;
      end
    end else begin
      position_next.fast = cur_pos.fast + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '{slow: '0, med: '0, fast: rcl_pkg::LETTER_W'(1)};
    end else if (in_valid && in_ready) begin
      position <= position_next;
    end
  end

  assign valid_c[0]      = in_valid;
  assign in_ready        = ready_c[0];
  assign tok_c[0].letter = letter_in_red;
  assign tok_c[0].pos    = cur_pos;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rcl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_sel (rcl_pkg::stage_of(i)),
      .in_valid  (valid_c[i]),
      .in_ready  (ready_c[i]),
      .in_tok    (tok_c[i]),
      .out_valid (valid_c[i+1]),
      .out_ready (ready_c[i+1]),
      .out_tok   (tok_c[i+1])
    );
  end

  assign ready_c[N]  = out_ready;
  assign out_valid   = valid_c[N];
  assign letter_out  = tok_c[N].letter;

endmodule

// ----- hw/rtl/rcl_checker.sv -----
// ----------------------------------------------------------------------------
// rcl_checker
// Port-level checks for the rotor cipher letter unit, bound to the top level.
// ----------------------------------------------------------------------------
module rcl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] letter_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(letter_out))
    else $error("stalled output transfer changed");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> letter_out < 5'd26)
    else $error("output letter out of range");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage empty");

endmodule

bind rotor_cipher_letter_unit rcl_checker u_rcl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .letter_out (letter_out)
);
